### rtl/cdp_pkg.sv
package cdp_pkg;

    // Field and register widths
    localparam int MODE_W     = 2;
    localparam int THR_W      = 24;
    localparam int NUM_W      = 20;
    localparam int PER_W      = 32;
    localparam int CPU_CNT_W  = 64;
    localparam int BUDGET_W   = 32;
    localparam int COUNT_W    = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Transaction modes
    localparam logic [MODE_W-1:0] MODE_BATCH       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC        = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET_ON      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOCK_RESET = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUMERATOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DENOMINATOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_PACING     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_DISABLED    = 3'd5;

    // Register reset values (period is 649.351 in 16.16)
    localparam logic [THR_W-1:0] RST_BATCH_THRESHOLD   = 24'd512;
    localparam logic [NUM_W-1:0] RST_RATIO_NUMERATOR   = 20'd282240;
    localparam logic [NUM_W-1:0] RST_RATIO_DENOMINATOR = 20'd715909;
    localparam logic [PER_W-1:0] RST_SAMPLE_PERIOD     = 32'd42555867;

    // Clamps and saturation limits
    localparam logic [THR_W-1:0]    MIN_BATCH  = 24'd128;
    localparam logic [PER_W-1:0]    MIN_PERIOD = 32'd65536;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 26'h3FF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SETUP,
        ST_DIV,
        ST_ACC,
        ST_BUDGET,
        ST_FINISH
    } cdp_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic setup;
        logic acc;
        logic budget;
        logic finish;
    } cdp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic flush_run;
        logic div_busy;
        logic out_free;
    } cdp_sts_t;

endpackage

### rtl/cdp_div.sv
module cdp_div #(
    parameter int N = 45,
    parameter int D = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);

    localparam int CNT_W = (N > 1) ? $clog2(N) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(N - 1);

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [N-1:0]     quo_reg;
    logic [N-1:0]     quo_next;
    logic [D-1:0]     rem_reg;
    logic [D-1:0]     rem_next;
    logic [D-1:0]     div_reg;
    logic [D:0]       shifted;
    logic [D:0]       trial;
    logic             fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[N-1]};
    assign fits    = (shifted >= {1'b0, div_reg});
    assign trial   = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[N-2:0], fits};
            rem_next = fits ? trial[D-1:0] : shifted[D-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/cdp_datapath.sv
module cdp_datapath #(
    parameter int CYCLE_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdp_pkg::cdp_cmd_t                 cmd,
    output cdp_pkg::cdp_sts_t                 sts,
    input  logic                              cfg_write,
    input  logic [cdp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cdp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [cdp_pkg::MODE_W-1:0]        mode,
    input  logic [CYCLE_BITS-1:0]             cycles,
    input  logic                              turn_on,
    input  logic                              cpu_halted,
    input  logic [cdp_pkg::CPU_CNT_W-1:0]     cpu_cycle_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cdp_pkg::BUDGET_W-1:0]      cpu_budget,
    output logic [cdp_pkg::COUNT_W-1:0]       sample_count,
    output logic                              cpu_reset,
    output logic                              chip_reset
);

    import cdp_pkg::*;

    localparam int SUM_W = ((CYCLE_BITS > THR_W) ? CYCLE_BITS : THR_W) + 1;
    localparam int ACC_W = SUM_W + NUM_W;
    localparam int SMP_W = SUM_W + 17;

    // Configuration registers
    logic [THR_W-1:0] thr_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] den_reg;
    logic [PER_W-1:0] per_reg;
    logic             legacy_reg;
    logic             disabled_reg;

    // Captured transaction
    logic [MODE_W-1:0]     mode_reg;
    logic [CYCLE_BITS-1:0] cyc_reg;
    logic                  turn_on_reg;
    logic                  halted_reg;
    logic [CPU_CNT_W-1:0]  cpu_cnt_reg;

    // Pacing state
    logic                 cpu_on_reg;
    logic                 cpu_on_next;
    logic [NUM_W-1:0]     ratio_rem_reg;
    logic [NUM_W-1:0]     ratio_rem_next;
    logic [CPU_CNT_W-1:0] target_reg;
    logic [CPU_CNT_W-1:0] target_next;
    logic [PER_W-1:0]     sample_rem_reg;
    logic [PER_W-1:0]     sample_rem_next;
    logic [THR_W-1:0]     pending_reg;
    logic [THR_W-1:0]     pending_next;

    // Work registers
    logic [SUM_W-1:0]    n_reg;
    logic [SUM_W-1:0]    n_next;
    logic [BUDGET_W-1:0] budget_reg;
    logic [BUDGET_W-1:0] budget_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BUDGET_W-1:0] out_budget_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_cpu_rst_reg;
    logic                out_chip_rst_reg;

    logic [THR_W-1:0]     thr_eff;
    logic [NUM_W-1:0]     den_eff;
    logic [PER_W-1:0]     per_eff;
    logic [SUM_W-1:0]     sum;
    logic                 is_batch;
    logic                 flush;
    logic                 pace;
    logic [ACC_W-1:0]     product;
    logic [ACC_W-1:0]     ratio_dividend;
    logic [SMP_W-1:0]     sample_dividend;
    logic                 busy_a;
    logic                 busy_b;
    logic [ACC_W-1:0]     quo_a;
    logic [NUM_W-1:0]     rem_a;
    logic [SMP_W-1:0]     quo_b;
    logic [PER_W-1:0]     rem_b;
    logic [CPU_CNT_W-1:0] target_sum;
    logic [CPU_CNT_W-1:0] cpu_gap;
    logic                 do_switch_on;
    logic                 do_clock_reset;
    logic                 cpu_rst_pulse;

    // Clamp the registers to their working ranges
    assign thr_eff = (thr_reg < MIN_BATCH) ? MIN_BATCH : thr_reg;
    assign den_eff = (den_reg == '0) ? NUM_W'(1) : den_reg;
    assign per_eff = (per_reg < MIN_PERIOD) ? MIN_PERIOD : per_reg;

    // Batch decision
    assign is_batch = (mode_reg == MODE_BATCH);
    assign sum      = SUM_W'(pending_reg) + SUM_W'(cyc_reg);
    assign flush    = is_batch ? (sum >= SUM_W'(thr_eff)) : (pending_reg != '0);
    assign pace     = cpu_on_reg && !halted_reg;

    // Dividends for the ratio and sample dividers
    assign product         = ACC_W'(n_reg) * ACC_W'(num_reg);
    assign ratio_dividend  = product + ACC_W'(ratio_rem_reg);
    assign sample_dividend = SMP_W'(sample_rem_reg) + SMP_W'({n_reg, 16'h0000});

    assign target_sum = target_reg + CPU_CNT_W'(quo_a);
    assign cpu_gap    = target_reg - cpu_cnt_reg;

    // Mode side effects applied once the transaction completes
    assign do_switch_on   = (mode_reg == MODE_SET_ON) && turn_on_reg && !cpu_on_reg;
    assign do_clock_reset = (mode_reg == MODE_CLOCK_RESET);
    assign cpu_rst_pulse  = do_switch_on || do_clock_reset;

    cdp_div #(
        .N (ACC_W),
        .D (NUM_W)
    ) u_ratio_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.setup),
        .dividend  (ratio_dividend),
        .divisor   (den_eff),
        .busy      (busy_a),
        .quotient  (quo_a),
        .remainder (rem_a)
    );

    cdp_div #(
        .N (SMP_W),
        .D (PER_W)
    ) u_sample_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.setup),
        .dividend  (sample_dividend),
        .divisor   (per_eff),
        .busy      (busy_b),
        .quotient  (quo_b),
        .remainder (rem_b)
    );

    // Next values of state and work registers
    always_comb
    begin
        cpu_on_next     = cpu_on_reg;
        ratio_rem_next  = ratio_rem_reg;
        target_next     = target_reg;
        sample_rem_next = sample_rem_reg;
        pending_next    = pending_reg;
        n_next          = n_reg;
        budget_next     = budget_reg;
        count_next      = count_reg;

        if (cmd.decide)
        begin
            budget_next = '0;
            count_next  = '0;
            n_next      = is_batch ? sum : SUM_W'(pending_reg);
            if (is_batch && !flush)
            begin
                pending_next = sum[THR_W-1:0];
            end
            else
            begin
                pending_next = '0;
            end
        end

        if (cmd.acc)
        begin
            if (pace)
            begin
                target_next    = target_sum;
                ratio_rem_next = rem_a;
                if (legacy_reg)
                begin
                    budget_next = (|quo_a[ACC_W-1:BUDGET_W]) ? BUDGET_MAX
                                                             : quo_a[BUDGET_W-1:0];
                end
            end
            sample_rem_next = rem_b;
            count_next      = (|quo_b[SMP_W-1:COUNT_W]) ? COUNT_MAX : quo_b[COUNT_W-1:0];
        end

        if (cmd.budget && pace && !legacy_reg && (cpu_cnt_reg < target_reg))
        begin
            budget_next = (|cpu_gap[CPU_CNT_W-1:BUDGET_W]) ? BUDGET_MAX
                                                          : cpu_gap[BUDGET_W-1:0];
        end

        if (cmd.finish)
        begin
            if (mode_reg == MODE_SET_ON)
            begin
                if (do_switch_on)
                begin
                    ratio_rem_next = '0;
                    target_next    = '0;
                    cpu_on_next    = 1'b1;
                end
                else if (!turn_on_reg)
                begin
                    cpu_on_next = 1'b0;
                end
            end
            else if (do_clock_reset)
            begin
                cpu_on_next     = 1'b0;
                ratio_rem_next  = '0;
                target_next     = '0;
                sample_rem_next = '0;
                pending_next    = '0;
            end
        end
    end

    // Drop the result once taken, load a new one on completion
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= RST_BATCH_THRESHOLD;
            num_reg      <= RST_RATIO_NUMERATOR;
            den_reg      <= RST_RATIO_DENOMINATOR;
            per_reg      <= RST_SAMPLE_PERIOD;
            legacy_reg   <= 1'b0;
            disabled_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BATCH_THRESHOLD:   thr_reg      <= cfg_data[THR_W-1:0];
                CFG_RATIO_NUMERATOR:   num_reg      <= cfg_data[NUM_W-1:0];
                CFG_RATIO_DENOMINATOR: den_reg      <= cfg_data[NUM_W-1:0];
                CFG_SAMPLE_PERIOD:     per_reg      <= cfg_data[PER_W-1:0];
                CFG_LEGACY_PACING:     legacy_reg   <= cfg_data[0];
                CFG_SOUND_DISABLED:    disabled_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Hold pacing state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_on_reg     <= 1'b0;
            ratio_rem_reg  <= '0;
            target_reg     <= '0;
            sample_rem_reg <= '0;
            pending_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cpu_on_reg     <= cpu_on_next;
            ratio_rem_reg  <= ratio_rem_next;
            target_reg     <= target_next;
            sample_rem_reg <= sample_rem_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the transaction, hold work values, load the output payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg    <= mode;
            cyc_reg     <= cycles;
            turn_on_reg <= turn_on;
            halted_reg  <= cpu_halted;
            cpu_cnt_reg <= cpu_cycle_count;
        end
        n_reg      <= n_next;
        budget_reg <= budget_next;
        count_reg  <= count_next;
        if (cmd.finish)
        begin
            out_budget_reg   <= budget_reg;
            out_count_reg    <= count_reg;
            out_cpu_rst_reg  <= cpu_rst_pulse;
            out_chip_rst_reg <= do_clock_reset;
        end
    end

    assign sts.flush_run = flush && !disabled_reg;
    assign sts.div_busy  = busy_a || busy_b;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign cpu_budget   = out_budget_reg;
    assign sample_count = out_count_reg;
    assign cpu_reset    = out_cpu_rst_reg;
    assign chip_reset   = out_chip_rst_reg;

endmodule

### rtl/cdp_ctrl.sv
module cdp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cdp_pkg::cdp_sts_t  sts,
    output cdp_pkg::cdp_cmd_t  cmd
);

    import cdp_pkg::*;

    cdp_state_t state_reg;
    cdp_state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = sts.flush_run ? ST_SETUP : ST_FINISH;
            end
            ST_SETUP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = ST_BUDGET;
            end
            ST_BUDGET:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_DECIDE: cmd.decide = 1'b1;
            ST_SETUP:  cmd.setup  = 1'b1;
            ST_ACC:    cmd.acc    = 1'b1;
            ST_BUDGET: cmd.budget = 1'b1;
            ST_FINISH: cmd.finish = sts.out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/clock_domain_pacer_core.sv
// Clock domain pacer: turns elapsed master cycles into a slave CPU budget and
// a count of output sample periods.
// Input channel (in_valid / in_stall) carries one transaction per advance:
// mode, cycles, turn_on, cpu_halted and cpu_cycle_count. Output channel
// (out_valid / out_stall) returns exactly one result per input transaction:
// cpu_budget, sample_count and the cpu_reset / chip_reset pulses.
// One transaction is worked on at a time. A transaction that only batches
// cycles, or a flush with nothing pending or with sound disabled, passes
// the decide and finish steps on its way to the output register.
// A flush runs the ratio and sample restoring dividers side by side, one
// quotient bit per cycle; the ratio divider is max(CYCLE_BITS, 24) + 21 bits
// wide, wider than the sample divider, and sets the time. A flush passes the
// decide, setup, divide, accumulate, budget and finish steps.
// in_stall is low only while the block is idle; a new transaction can be
// accepted while the previous result still sits in the output register. If
// the receiver stalls, the result holds and the next transaction waits at
// its last step until the output register frees.
// Reset restores the register defaults, clears all pacing state and leaves
// the output empty; no clearing pass is needed.
module clock_domain_pacer_core #(
    parameter int CYCLE_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cdp_pkg::MODE_W-1:0]     mode,
    input  logic [CYCLE_BITS-1:0]          cycles,
    input  logic                           turn_on,
    input  logic                           cpu_halted,
    input  logic [cdp_pkg::CPU_CNT_W-1:0]  cpu_cycle_count,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cdp_pkg::BUDGET_W-1:0]   cpu_budget,
    output logic [cdp_pkg::COUNT_W-1:0]    sample_count,
    output logic                           cpu_reset,
    output logic                           chip_reset
);

    import cdp_pkg::*;

    cdp_cmd_t cmd;
    cdp_sts_t sts;

    cdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdp_datapath #(
        .CYCLE_BITS (CYCLE_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .cycles          (cycles),
        .turn_on         (turn_on),
        .cpu_halted      (cpu_halted),
        .cpu_cycle_count (cpu_cycle_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cpu_budget      (cpu_budget),
        .sample_count    (sample_count),
        .cpu_reset       (cpu_reset),
        .chip_reset      (chip_reset)
    );

    // An accepted transaction blocks the input until it completes
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not blocked after acceptance");

    // The dividers only run while a transaction is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_busy |-> in_stall)
        else $error("divider busy while idle");

    // A chip reset always comes with a CPU reset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chip_reset |-> cpu_reset)
        else $error("chip reset without cpu reset");

    // A completed transaction lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("result lost on completion");

endmodule

### tb/clock_domain_pacer_core_tb.sv
module clock_domain_pacer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 80;

    // One input transaction and one result, at the block's widths
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [23:0]          cycles;
        logic                 turn_on;
        logic                 cpu_halted;
        logic [CPU_CNT_W-1:0] cpu_cycle_count;
    } advance_t;

    typedef struct packed {
        logic [BUDGET_W-1:0] cpu_budget;
        logic [COUNT_W-1:0]  sample_count;
        logic                cpu_reset;
        logic                chip_reset;
    } grant_t;

    // A queued count is either absolute or an offset from the pacing target
    // as it stands when the transaction is put on the bus
    typedef enum logic {
        CNT_FIXED,
        CNT_NEAR_TARGET
    } count_kind_t;

    typedef struct packed {
        advance_t    adv;
        count_kind_t kind;
    } queued_advance_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [MODE_W-1:0]      mode = MODE_BATCH;
    logic [23:0]            cycles = '0;
    logic                   turn_on = 1'b0;
    logic                   cpu_halted = 1'b0;
    logic [CPU_CNT_W-1:0]   cpu_cycle_count = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BUDGET_W-1:0]    cpu_budget;
    logic [COUNT_W-1:0]     sample_count;
    logic                   cpu_reset;
    logic                   chip_reset;

    // Register copies as the block should hold them
    logic [THR_W-1:0]  set_thr;
    logic [NUM_W-1:0]  set_num;
    logic [NUM_W-1:0]  set_den;
    logic [PER_W-1:0]  set_period;
    logic              set_legacy;
    logic              set_sound_off;

    // Pacing state of the predictor
    logic              m_cpu_on;
    logic [NUM_W-1:0]  m_ratio_rem;
    logic [63:0]       m_target;
    logic [PER_W-1:0]  m_sample_rem;
    logic [24:0]       m_pending;

    queued_advance_t   queued_advances[$];
    grant_t            predicted_grants[$];
    advance_t          cur_advance;
    grant_t            drv_grant;
    grant_t            seen_grant;
    logic              drv_next_valid;
    int unsigned       drv_gap;
    int unsigned       calm_left;
    logic              calm = 1'b0;
    int unsigned       stall_left;
    logic              cpu_parked;
    int unsigned       cycle_count;
    int unsigned       errors;
    int unsigned       n_accepted;
    int unsigned       n_checked;
    int unsigned       n_flushes;
    int unsigned       n_paced;
    int unsigned       n_saturated;
    int unsigned       n_settings;

    clock_domain_pacer_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .cycles          (cycles),
        .turn_on         (turn_on),
        .cpu_halted      (cpu_halted),
        .cpu_cycle_count (cpu_cycle_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cpu_budget      (cpu_budget),
        .sample_count    (sample_count),
        .cpu_reset       (cpu_reset),
        .chip_reset      (chip_reset)
    );

    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one; none in a calm stretch
    function automatic int unsigned pick_gap(input logic quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    // Move both clock domains on by n master cycles
    task automatic advance_domains(input logic [63:0] n, input logic halted,
                                   input logic [63:0] count,
                                   output logic [BUDGET_W-1:0] budget,
                                   output logic [COUNT_W-1:0] periods);
        logic [63:0] den;
        logic [63:0] acc;
        logic [63:0] whole;
        logic [63:0] per;
        logic [63:0] total;
        logic [63:0] quo;
        budget = '0;
        periods = '0;
        n_flushes++;
        if (!set_sound_off)
        begin
            if (m_cpu_on && !halted)
            begin
                den = (set_den == '0) ? 64'd1 : 64'(set_den);
                acc = 64'(m_ratio_rem) + n * 64'(set_num);
                whole = acc / den;
                m_ratio_rem = NUM_W'(acc % den);
                m_target = m_target + whole;
                if (set_legacy)
                    budget = (whole > 64'(BUDGET_MAX)) ? BUDGET_MAX : whole[31:0];
                else if (count < m_target)
                    budget = (m_target - count > 64'(BUDGET_MAX)) ? BUDGET_MAX
                                                                  : BUDGET_W'(m_target - count);
                n_paced++;
                if (budget == BUDGET_MAX)
                    n_saturated++;
            end
            per = (set_period < MIN_PERIOD) ? 64'(MIN_PERIOD) : 64'(set_period);
            total = 64'(m_sample_rem) + (n << 16);
            quo = total / per;
            m_sample_rem = PER_W'(total % per);
            periods = (quo > 64'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(quo);
        end
    endtask

    // Work out the result of one accepted transaction and update the state
    task automatic pace_advance(input advance_t a, output grant_t g);
        logic [63:0] thr;
        logic [63:0] sum;
        g = '0;
        if (a.mode == MODE_BATCH)
        begin
            thr = (set_thr < MIN_BATCH) ? 64'(MIN_BATCH) : 64'(set_thr);
            sum = 64'(m_pending) + 64'(a.cycles);
            if (sum < thr)
                m_pending = 25'(sum);
            else
            begin
                m_pending = '0;
                advance_domains(sum, a.cpu_halted, a.cpu_cycle_count,
                                g.cpu_budget, g.sample_count);
            end
        end
        else
        begin
            if (m_pending != '0)
            begin
                sum = 64'(m_pending);
                m_pending = '0;
                advance_domains(sum, a.cpu_halted, a.cpu_cycle_count,
                                g.cpu_budget, g.sample_count);
            end
            if (a.mode == MODE_SET_ON)
            begin
                if (a.turn_on && !m_cpu_on)
                begin
                    m_ratio_rem = '0;
                    m_target = '0;
                    m_cpu_on = 1'b1;
                    g.cpu_reset = 1'b1;
                end
                else if (!a.turn_on)
                    m_cpu_on = 1'b0;
            end
            else if (a.mode == MODE_CLOCK_RESET)
            begin
                m_cpu_on = 1'b0;
                m_ratio_rem = '0;
                m_target = '0;
                m_sample_rem = '0;
                m_pending = '0;
                g.cpu_reset = 1'b1;
                g.chip_reset = 1'b1;
            end
        end
    endtask

    // Write one register; the enable stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_BATCH_THRESHOLD:   set_thr = data[THR_W-1:0];
            CFG_RATIO_NUMERATOR:   set_num = data[NUM_W-1:0];
            CFG_RATIO_DENOMINATOR: set_den = data[NUM_W-1:0];
            CFG_SAMPLE_PERIOD:     set_period = data;
            CFG_LEGACY_PACING:     set_legacy = data[0];
            CFG_SOUND_DISABLED:    set_sound_off = data[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    task automatic push_advance(input logic [MODE_W-1:0] m, input logic [23:0] c,
                                input logic on, input logic h,
                                input count_kind_t kind, input logic [63:0] count);
        queued_advance_t q;
        q.adv.mode = m;
        q.adv.cycles = c;
        q.adv.turn_on = on;
        q.adv.cpu_halted = h;
        q.adv.cpu_cycle_count = count;
        q.kind = kind;
        queued_advances.push_back(q);
    endtask

    // Mostly well-formed pacing: switch on, batch, sync; with halts and resets
    task automatic add_random_advances(input int unsigned count);
        int unsigned k;
        int unsigned r;
        int unsigned eff_thr;
        int off;
        logic [MODE_W-1:0] m;
        logic [23:0] c;
        logic on;
        count_kind_t kind;
        logic [63:0] v;
        eff_thr = (set_thr < MIN_BATCH) ? 32'(MIN_BATCH) : 32'(set_thr);
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            on = ($urandom_range(0, 4) != 0);
            if (cpu_parked && r < 70)
            begin
                m = MODE_SET_ON;
                on = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m = MODE_BATCH;
                else if (r < 80)
                    m = MODE_SYNC;
                else if (r < 92)
                    m = MODE_SET_ON;
                else
                    m = MODE_CLOCK_RESET;
            end
            cpu_parked = (m == MODE_CLOCK_RESET) || (m == MODE_SET_ON && !on);
            r = $urandom_range(0, 99);
            if (r < 8)
                c = '0;
            else if (r < 20)
                c = 24'($urandom);
            else
                c = 24'($urandom_range(0, eff_thr * 3 / 4));
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                off = int'($urandom_range(0, 700)) - 300;
                kind = CNT_NEAR_TARGET;
                v = 64'(longint'(off));
            end
            else if (r < 85)
            begin
                kind = CNT_FIXED;
                v = {$urandom, $urandom};
            end
            else
            begin
                kind = CNT_FIXED;
                v = 64'($urandom_range(0, 2000));
            end
            push_advance(m, c, on, ($urandom_range(0, 6) == 0), kind, v);
        end
    endtask

    task automatic wait_idle();
        while (queued_advances.size() != 0 || in_valid || predicted_grants.size() != 0)
            @(posedge clk);
    endtask

    // Driver: present queued transactions, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            drv_gap = 0;
            calm_left = 30;
        end
        else
        begin
            drv_next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                pace_advance(cur_advance, drv_grant);
                predicted_grants.push_back(drv_grant);
                n_accepted++;
                drv_next_valid = 1'b0;
                drv_gap = pick_gap(calm);
                if (calm_left == 0)
                begin
                    calm <= ($urandom_range(0, 3) == 0);
                    calm_left = $urandom_range(20, 60);
                end
                else
                    calm_left--;
            end
            if (!drv_next_valid)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (queued_advances.size() != 0)
                begin
                    cur_advance = queued_advances[0].adv;
                    if (queued_advances[0].kind == CNT_NEAR_TARGET)
                        cur_advance.cpu_cycle_count = m_target + cur_advance.cpu_cycle_count;
                    void'(queued_advances.pop_front());
                    mode <= cur_advance.mode;
                    cycles <= cur_advance.cycles;
                    turn_on <= cur_advance.turn_on;
                    cpu_halted <= cur_advance.cpu_halted;
                    cpu_cycle_count <= cur_advance.cpu_cycle_count;
                    drv_next_valid = 1'b1;
                end
            end
            in_valid <= drv_next_valid;
        end
    end

    // Monitor: check each result against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_grants.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    errors++;
                end
                else
                begin
                    seen_grant = predicted_grants.pop_front();
                    n_checked++;
                    if (cpu_budget !== seen_grant.cpu_budget)
                    begin
                        $error("cpu_budget: expected %0d, got %0d",
                               seen_grant.cpu_budget, cpu_budget);
                        errors++;
                    end
                    if (sample_count !== seen_grant.sample_count)
                    begin
                        $error("sample_count: expected %0d, got %0d",
                               seen_grant.sample_count, sample_count);
                        errors++;
                    end
                    if (cpu_reset !== seen_grant.cpu_reset)
                    begin
                        $error("cpu_reset: expected %0d, got %0d",
                               seen_grant.cpu_reset, cpu_reset);
                        errors++;
                    end
                    if (chip_reset !== seen_grant.chip_reset)
                    begin
                        $error("chip_reset: expected %0d, got %0d",
                               seen_grant.chip_reset, chip_reset);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(calm);
            end
        end
    end

    // Give up on a hung block
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        set_thr = RST_BATCH_THRESHOLD;
        set_num = RST_RATIO_NUMERATOR;
        set_den = RST_RATIO_DENOMINATOR;
        set_period = RST_SAMPLE_PERIOD;
        set_legacy = 1'b0;
        set_sound_off = 1'b0;
        m_cpu_on = 1'b0;
        m_ratio_rem = '0;
        m_target = '0;
        m_sample_rem = '0;
        m_pending = '0;
        cpu_parked = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: walk through every mode and the pacing corner cases
        push_advance(MODE_SYNC, 24'd0, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_SET_ON, 24'd0, 1'b1, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_SET_ON, 24'd0, 1'b1, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_BATCH, 24'd0, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'd100, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'd411, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'd1, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'hFF_FFFF, 1'b0, 1'b0, CNT_NEAR_TARGET, -64'd100);
        push_advance(MODE_BATCH, 24'd300, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_SYNC, 24'd0, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'd300, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_SYNC, 24'd0, 1'b0, 1'b1, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'd200, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_SET_ON, 24'd0, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_BATCH, 24'hFF_FFFF, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_SET_ON, 24'hFF_FFFF, 1'b1, 1'b1, CNT_FIXED, '1);
        push_advance(MODE_BATCH, 24'd600, 1'b0, 1'b0, CNT_FIXED, '1);
        push_advance(MODE_BATCH, 24'd600, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd100000);
        push_advance(MODE_BATCH, 24'd600, 1'b0, 1'b0, CNT_NEAR_TARGET, -64'd5);
        push_advance(MODE_BATCH, 24'd300, 1'b0, 1'b0, CNT_NEAR_TARGET, 64'd0);
        push_advance(MODE_CLOCK_RESET, 24'd0, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_CLOCK_RESET, 24'd0, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        cpu_parked = 1'b1;
        add_random_advances(45);
        wait_idle();

        // Extreme low corner in legacy pacing: clamped threshold and period
        write_reg(CFG_BATCH_THRESHOLD, 32'd0);
        write_reg(CFG_RATIO_NUMERATOR, 32'h000F_FFFF);
        write_reg(CFG_RATIO_DENOMINATOR, 32'd1);
        write_reg(CFG_SAMPLE_PERIOD, 32'd0);
        write_reg(CFG_LEGACY_PACING, 32'd1);
        write_reg(CFG_SOUND_DISABLED, 32'd0);
        end_writes();
        push_advance(MODE_SET_ON, 24'd0, 1'b1, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_BATCH, 24'hFF_FFFF, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_BATCH, 24'd127, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_BATCH, 24'd1, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        cpu_parked = 1'b0;
        add_random_advances(46);
        wait_idle();

        // Same ratio, budget from the target: saturates against a small count
        write_reg(CFG_LEGACY_PACING, 32'd0);
        end_writes();
        push_advance(MODE_SET_ON, 24'd0, 1'b1, 1'b0, CNT_FIXED, 64'd0);
        push_advance(MODE_BATCH, 24'hFF_FFFF, 1'b0, 1'b0, CNT_FIXED, 64'd0);
        add_random_advances(48);
        wait_idle();

        // Extreme high corner, zero numerator and zero denominator
        write_reg(CFG_BATCH_THRESHOLD, 32'h00FF_FFFF);
        write_reg(CFG_RATIO_NUMERATOR, 32'd0);
        write_reg(CFG_RATIO_DENOMINATOR, 32'd0);
        write_reg(CFG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
        end_writes();
        add_random_advances(50);
        wait_idle();

        // Sound disabled: flushes drain pending cycles only
        write_reg(CFG_BATCH_THRESHOLD, 32'd127);
        write_reg(CFG_RATIO_NUMERATOR, 32'(RST_RATIO_NUMERATOR));
        write_reg(CFG_RATIO_DENOMINATOR, 32'(RST_RATIO_DENOMINATOR));
        write_reg(CFG_SAMPLE_PERIOD, 32'(RST_SAMPLE_PERIOD));
        write_reg(CFG_SOUND_DISABLED, 32'd1);
        end_writes();
        add_random_advances(50);
        wait_idle();

        // Random settings, with stray upper bits on the narrow registers
        write_reg(CFG_BATCH_THRESHOLD, {8'($urandom), 24'($urandom_range(128, 4096))});
        write_reg(CFG_RATIO_NUMERATOR, {12'($urandom), 20'($urandom)});
        write_reg(CFG_RATIO_DENOMINATOR, {12'($urandom), 20'($urandom_range(1, 1048575))});
        write_reg(CFG_SAMPLE_PERIOD, $urandom_range(65536, 32'h0800_0000));
        write_reg(CFG_LEGACY_PACING, $urandom);
        write_reg(CFG_SOUND_DISABLED, {31'($urandom), 1'b0});
        end_writes();
        add_random_advances(50);
        wait_idle();

        // Widest ratio with the period just under its clamp
        write_reg(CFG_BATCH_THRESHOLD, 32'd128);
        write_reg(CFG_RATIO_NUMERATOR, 32'h000F_FFFF);
        write_reg(CFG_RATIO_DENOMINATOR, 32'h000F_FFFF);
        write_reg(CFG_SAMPLE_PERIOD, 32'd65535);
        write_reg(CFG_LEGACY_PACING, 32'd0);
        end_writes();
        add_random_advances(50);
        wait_idle();

        // Back to the reset values, legacy pacing
        write_reg(CFG_BATCH_THRESHOLD, 32'(RST_BATCH_THRESHOLD));
        write_reg(CFG_RATIO_NUMERATOR, 32'(RST_RATIO_NUMERATOR));
        write_reg(CFG_RATIO_DENOMINATOR, 32'(RST_RATIO_DENOMINATOR));
        write_reg(CFG_SAMPLE_PERIOD, 32'(RST_SAMPLE_PERIOD));
        write_reg(CFG_LEGACY_PACING, 32'd1);
        end_writes();
        add_random_advances(50);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Pacer run: %0d transactions over %0d register settings, %0d results checked",
                 n_accepted, n_settings + 1, n_checked);
        $display("Pacer run: %0d flushes, %0d paced budgets, %0d saturated budgets",
                 n_flushes, n_paced, n_saturated);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
